/* hw/rtl/simon32_64_block_cipher_macros.svh */
// assertion macros for the simon32/64 cipher checker
// no dependencies; included by the checker file
`ifndef SIMON32_64_BLOCK_CIPHER_MACROS_SVH
`define SIMON32_64_BLOCK_CIPHER_MACROS_SVH

// same-cycle implication
`define SIMON_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("simon check failed");

// next-cycle implication
`define SIMON_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("simon check failed");

// implication after a fixed delay
`define SIMON_ASSERT_DLY(lbl, clk, rst_n, dly, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> ##dly (cons)) \
        else $error("simon check failed");

`endif

/* hw/rtl/simon_pkg.sv */
// constants and types shared by the simon32/64 cipher and its checker
// no dependencies
`default_nettype none

package simon_pkg;

    localparam int WORD_W    = 16;
    localparam int BLOCK_W   = 2 * WORD_W;
    localparam int DIGIT_W   = 4;
    localparam int DIGITS    = WORD_W / DIGIT_W;
    localparam int DIG_W     = $clog2(DIGITS);
    localparam int ROUNDS    = 32;
    localparam int RND_W     = $clog2(ROUNDS);
    localparam int KEY_WORDS = 4;
    localparam int KEY_IDX_W = $clog2(KEY_WORDS);
    localparam int LATENCY   = 2 + ROUNDS * DIGITS;

    localparam logic [WORD_W-1:0] SCHED_CONST = 16'hfffc;
    localparam logic [61:0]       Z0_SEQ      = 62'h19C3522FB386A45F;

    typedef logic [WORD_W-1:0] t_word;

endpackage

`default_nettype wire

/* hw/rtl/simon32_64_block_cipher.sv */
// simon32/64 block cipher: key schedule, round key memory, 4-bit digit-serial rounds
// depends on simon_pkg
//
// usage:
//   config: i_cfg_we writes i_cfg_wdata into key word i_cfg_addr (0..3) at once,
//   and starts a key expansion that keeps busy high while the 32 round keys
//   are written to a 32x16 memory, one key per cycle
//   request: a beat is taken when start is high and busy is low; i_req_type
//   picks encrypt (0) or decrypt (1), i_block_in holds x in the upper half
//   result: o_block_out is shown for one cycle with o_done high after the
//   last round; busy stays high until then, so a new block is taken only
//   once the last one is done
//   rounds: a prime state fetches the first round key, then each of the 32
//   rounds passes one 4-bit digit of the new word per cycle through the
//   round function; the next round key is read from the memory port during
//   the last digit of a round
//   reset: clears the key words to zero and runs the expansion of the all-zero
//   key, so busy is high after reset until that expansion is done
//   the receiver cannot stall: o_done is not held past its one cycle
`default_nettype none

module simon32_64_block_cipher (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic                              i_req_type,
    input  logic [simon_pkg::BLOCK_W-1:0]     i_block_in,
    output logic                              o_done,
    output logic [simon_pkg::BLOCK_W-1:0]     o_block_out,
    input  logic                              i_cfg_we,
    input  logic [simon_pkg::KEY_IDX_W-1:0]   i_cfg_addr,
    input  logic [simon_pkg::WORD_W-1:0]      i_cfg_wdata
);

    import simon_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PRIME,
        ST_RUN
    } t_state;

    localparam logic [ROUNDS-1:0] Z_LO     = Z0_SEQ[ROUNDS-1:0];
    localparam logic [RND_W-1:0]  RND_LAST = RND_W'(ROUNDS - 1);
    localparam logic [DIG_W-1:0]  DIG_LAST = DIG_W'(DIGITS - 1);

    // key words and expansion window
    t_word            r_kw  [KEY_WORDS];
    t_word            n_kw  [KEY_WORDS];
    t_word            r_win [KEY_WORDS];
    logic [RND_W-1:0] r_exp_cnt;
    logic             r_exp_run;
    t_word            exp_t;
    t_word            exp_u;
    t_word            exp_new;

    // round key memory
    t_word            r_rk_mem [ROUNDS];
    t_word            r_rk;
    logic             rd_en;
    logic [RND_W-1:0] rd_rnd;
    logic [RND_W-1:0] rd_addr;

    // round datapath
    t_state             r_state;
    t_word              r_a;
    t_word              r_b;
    logic               r_dec;
    logic [RND_W-1:0]   r_rnd;
    logic [DIG_W-1:0]   r_dig;
    logic [DIGIT_W-1:0] f_dig;
    logic [DIGIT_W-1:0] k_dig;
    logic [DIGIT_W-1:0] t_dig;
    t_word              b_shift;
    t_word              a_rot;
    logic               last_dig;
    logic               last_rnd;
    logic               accept;

    always_comb begin
        for (int i = 0; i < KEY_WORDS; i++) begin
            n_kw[i] = r_kw[i];
        end
        n_kw[i_cfg_addr] = i_cfg_wdata;
    end

    // next schedule word from k[i], k[i+1], k[i+3]
    always_comb begin
        exp_t   = {r_win[3][2:0], r_win[3][WORD_W-1:3]} ^ r_win[1];
        exp_u   = exp_t ^ {exp_t[0], exp_t[WORD_W-1:1]};
        exp_new = r_win[0] ^ exp_u ^ SCHED_CONST
                ^ {{(WORD_W-1){1'b0}}, Z_LO[r_exp_cnt]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < KEY_WORDS; i++) begin
                r_kw[i]  <= '0;
                r_win[i] <= '0;
            end
            r_exp_cnt <= '0;
            r_exp_run <= 1'b1;
        end else if (i_cfg_we) begin
            for (int i = 0; i < KEY_WORDS; i++) begin
                r_kw[i]  <= n_kw[i];
                r_win[i] <= n_kw[i];
            end
            r_exp_cnt <= '0;
            r_exp_run <= 1'b1;
        end else if (r_exp_run) begin
            for (int i = 0; i < KEY_WORDS - 1; i++) begin
                r_win[i] <= r_win[i+1];
            end
            r_win[KEY_WORDS-1] <= exp_new;
            r_exp_cnt          <= r_exp_cnt + RND_W'(1);
            if (r_exp_cnt == RND_LAST) begin
                r_exp_run <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_exp_run) begin
            r_rk_mem[r_exp_cnt] <= r_win[0];
        end
    end

    always_comb begin
        last_dig = (r_dig == DIG_LAST);
        last_rnd = (r_rnd == RND_LAST);
        rd_en    = (r_state == ST_PRIME) || ((r_state == ST_RUN) && last_dig);
        rd_rnd   = (r_state == ST_PRIME) ? r_rnd : r_rnd + RND_W'(1);
        rd_addr  = r_dec ? ~rd_rnd : rd_rnd;
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rk <= r_rk_mem[rd_addr];
        end
    end

    // one digit of the new word: f commutes with rotation, so taps stay fixed
    always_comb begin
        for (int m = 0; m < DIGIT_W; m++) begin
            f_dig[m] = (r_a[(m + WORD_W - 1) % WORD_W] & r_a[(m + WORD_W - 8) % WORD_W])
                     ^ r_a[(m + WORD_W - 2) % WORD_W];
        end
        k_dig   = r_rk[DIGIT_W * r_dig +: DIGIT_W];
        t_dig   = r_b[DIGIT_W-1:0] ^ f_dig ^ k_dig;
        b_shift = {t_dig, r_b[WORD_W-1:DIGIT_W]};
        a_rot   = {r_a[DIGIT_W-1:0], r_a[WORD_W-1:DIGIT_W]};
    end

    assign busy   = (r_state != ST_IDLE) || r_exp_run;
    assign accept = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_rnd   <= '0;
            r_dig   <= '0;
            o_done  <= 1'b0;
        end else begin
            o_done <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_dec <= i_req_type;
                        r_a   <= i_req_type ? i_block_in[WORD_W-1:0]
                                            : i_block_in[BLOCK_W-1:WORD_W];
                        r_b   <= i_req_type ? i_block_in[BLOCK_W-1:WORD_W]
                                            : i_block_in[WORD_W-1:0];
                        r_rnd   <= '0;
                        r_dig   <= '0;
                        r_state <= ST_PRIME;
                    end
                end
                ST_PRIME: begin
                    r_state <= ST_RUN;
                end
                ST_RUN: begin
                    r_dig <= r_dig + DIG_W'(1);
                    if (last_dig) begin
                        r_a   <= b_shift;
                        r_b   <= a_rot;
                        r_rnd <= r_rnd + RND_W'(1);
                        if (last_rnd) begin
                            r_state     <= ST_IDLE;
                            o_done      <= 1'b1;
                            o_block_out <= r_dec ? {a_rot, b_shift} : {b_shift, a_rot};
                        end
                    end else begin
                        r_a <= a_rot;
                        r_b <= b_shift;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/simon_chk.sv */
// port-level checker for the simon32/64 cipher, bound to the top level
// depends on simon_pkg and simon32_64_block_cipher_macros.svh
`default_nettype none
`include "simon32_64_block_cipher_macros.svh"

module simon_chk (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic o_done,
    input logic i_cfg_we
);

    import simon_pkg::*;

    `SIMON_ASSERT_DLY(a_latency, i_clk, i_rst_n, LATENCY, start && !busy, o_done)
    `SIMON_ASSERT_NXT(a_busy_after_beat, i_clk, i_rst_n, start && !busy, busy)
    `SIMON_ASSERT_NXT(a_done_single, i_clk, i_rst_n, o_done, !o_done)
    `SIMON_ASSERT_NXT(a_busy_after_key, i_clk, i_rst_n, i_cfg_we, busy)
    `SIMON_ASSERT_IMP(a_done_idle, i_clk, i_rst_n, o_done, !busy)

endmodule

bind simon32_64_block_cipher simon_chk u_simon_chk (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_done   (o_done),
    .i_cfg_we (i_cfg_we)
);

`default_nettype wire
